/* sv/svsd_pkg.sv */
package svsd_pkg;

  typedef enum logic [1:0] {
    MODE_BINARY  = 2'd0,
    MODE_DECIMAL = 2'd1,
    MODE_HEX     = 2'd2,
    MODE_OFF     = 2'd3
  } display_mode_e;

  localparam logic CFG_DISPLAY_MODE    = 1'b0;
  localparam logic CFG_UPDATE_INTERVAL = 1'b1;

  localparam logic [15:0] INTERVAL_RESET = 16'd500;

  localparam logic [7:0] CMD_DATA   = 8'h40;
  localparam logic [7:0] CMD_ADDR   = 8'hC0;
  localparam logic [7:0] CMD_BRIGHT = 8'h8F;
  localparam logic [7:0] SEG_BLANK  = 8'h00;

  localparam logic [2:0] IDX_DATA   = 3'd0;
  localparam logic [2:0] IDX_ADDR   = 3'd1;
  localparam logic [2:0] IDX_DIG0   = 3'd2;
  localparam logic [2:0] IDX_DIG1   = 3'd3;
  localparam logic [2:0] IDX_DIG2   = 3'd4;
  localparam logic [2:0] IDX_DIG3   = 3'd5;
  localparam logic [2:0] IDX_BRIGHT = 3'd6;

  // Four segment bytes of one refresh, leftmost digit first.
  typedef logic [3:0][7:0] run_t;

  typedef struct packed {
    logic not_empty;
    run_t head;
  } queue_status_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'h0: code = 8'h3F;
      4'h1: code = 8'h06;
      4'h2: code = 8'h5B;
      4'h3: code = 8'h4F;
      4'h4: code = 8'h66;
      4'h5: code = 8'h6D;
      4'h6: code = 8'h7D;
      4'h7: code = 8'h07;
      4'h8: code = 8'h7F;
      4'h9: code = 8'h6F;
      4'hA: code = 8'h77;
      4'hB: code = 8'h7C;
      4'hC: code = 8'h39;
      4'hD: code = 8'h5E;
      4'hE: code = 8'h79;
      4'hF: code = 8'h71;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

/* sv/switch_view_segment_display_top.sv */
// Switch-view seven-segment display formatter.
// Input channel: one tick word per accepted item (in_valid_i high, in_stall_o low),
// carrying the free-running tick count and the switch bank value.
// Output channel: display command words, one byte each with start, stop and
// end-of-run flags, taken when out_valid_o is high and out_stall_i is low.
// A due tick in a showing mode yields a run of seven words: 0x40, 0xC0 and four
// segment bytes, then 0x8F. Ticks that are not due, or due in the off mode,
// yield nothing but still renew the update time where due.
// The front accepts a tick in every cycle while the two-entry run queue has
// room; a run is written into the queue and its first word is then loaded into
// the output register. The back emits one word per cycle while a run is queued
// and the receiver does not stall, so sustained throughput of refreshing ticks
// is set by the single output byte lane.
// When the receiver stalls, the output word holds, the back stops, and once the
// queue fills the input channel stalls in turn.
// Reset clears the queue, the output valid flag and the update time, and sets
// step position 1, mode decimal, interval 500 ticks. The configuration port is
// always ready; the user must write it only while idle, which is not enforced.
module switch_view_segment_display_top import svsd_pkg::*; #(
  parameter int SWITCH_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] tick_now_i,
  input  logic [7:0]  switches_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        frame_begin_o,
  output logic        frame_end_o,
  output logic        run_last_o
);

  logic          accept;
  logic          push;
  logic          pop;
  logic          full;
  run_t          run;
  queue_status_t status;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  svsd_front #(
    .SWITCH_COUNT(SWITCH_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .tick_now_i (tick_now_i),
    .switches_i (switches_i),
    .push_o     (push),
    .run_o      (run)
  );

  svsd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(run),
    .pop_i      (pop),
    .full_o     (full),
    .status_o   (status)
  );

  svsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .status_i     (status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .frame_begin_o(frame_begin_o),
    .frame_end_o  (frame_end_o),
    .run_last_o   (run_last_o)
  );

endmodule

/* sv/svsd_front.sv */
module svsd_front import svsd_pkg::*; #(
  parameter int SWITCH_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        accept_i,
  input  logic [31:0] tick_now_i,
  input  logic [7:0]  switches_i,
  output logic        push_o,
  output run_t        run_o
);

  localparam logic [3:0] PosMax = 4'(SWITCH_COUNT);

  display_mode_e mode_q;
  logic [15:0]   interval_q;
  logic [31:0]   last_tick_q, last_tick_d;
  logic [3:0]    pos_q, pos_d;

  logic [31:0] elapsed;
  logic        due;
  logic [3:0]  pos_use, pos_m1;
  logic        pos_bit;
  logic [1:0]  hundreds;
  logic [6:0]  rem_h;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic [15:0] h_prod;
  logic [17:0] t_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_DECIMAL;
      interval_q <= INTERVAL_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_DISPLAY_MODE) begin
        mode_q <= display_mode_e'(cfg_data_i[1:0]);
      end else begin
        interval_q <= cfg_data_i;
      end
    end
  end

  assign elapsed = tick_now_i - last_tick_q;
  assign due     = elapsed >= {16'd0, interval_q};

  always_comb begin
    pos_use = pos_q;
    if (pos_q == 4'd0 || pos_q > PosMax) begin
      pos_use = 4'd1;
    end
    pos_m1  = pos_use - 4'd1;
    pos_bit = (pos_m1 < 4'd8) ? switches_i[pos_m1[2:0]] : 1'b0;
  end

  // Decimal digits by reciprocal multiplication, exact for eight-bit values.
  always_comb begin
    h_prod   = 16'(switches_i) * 16'd41;
    hundreds = h_prod[13:12];
    rem_h    = 7'(switches_i - 8'(hundreds) * 8'd100);
    t_prod   = 18'(rem_h) * 18'd205;
    tens     = t_prod[14:11];
    ones     = 4'(rem_h - 7'(tens) * 7'd10);
  end

  always_comb begin
    run_o = '0;
    case (mode_q)
      MODE_BINARY: begin
        run_o[0] = SEG_BLANK;
        run_o[1] = seg_code(pos_use);
        run_o[2] = SEG_BLANK;
        run_o[3] = seg_code({3'd0, pos_bit});
      end
      MODE_DECIMAL: begin
        run_o[0] = SEG_BLANK;
        run_o[1] = (switches_i >= 8'd100) ? seg_code({2'd0, hundreds}) : SEG_BLANK;
        run_o[2] = (switches_i >= 8'd10) ? seg_code(tens) : SEG_BLANK;
        run_o[3] = seg_code(ones);
      end
      MODE_HEX: begin
        run_o[0] = SEG_BLANK;
        run_o[1] = SEG_BLANK;
        run_o[2] = seg_code(switches_i[7:4]);
        run_o[3] = seg_code(switches_i[3:0]);
      end
      default: run_o = '0;
    endcase
  end

  always_comb begin
    last_tick_d = last_tick_q;
    pos_d       = pos_q;
    push_o      = 1'b0;
    if (accept_i && due) begin
      last_tick_d = tick_now_i;
      push_o      = (mode_q != MODE_OFF);
      if (mode_q == MODE_BINARY) begin
        pos_d = (pos_use >= PosMax) ? 4'd1 : pos_use + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_tick_q <= '0;
      pos_q       <= 4'd1;
    end else begin
      last_tick_q <= last_tick_d;
      pos_q       <= pos_d;
    end
  end

endmodule

/* sv/svsd_queue.sv */
module svsd_queue import svsd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  run_t          push_data_i,
  input  logic          pop_i,
  output logic          full_o,
  output queue_status_t status_o
);

  run_t       mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o             = (count_q == 2'd2);
  assign status_o.not_empty = (count_q != 2'd0);
  assign status_o.head      = mem[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

/* sv/svsd_back.sv */
module svsd_back import svsd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  queue_status_t status_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    frame_byte_o,
  output logic          frame_begin_o,
  output logic          frame_end_o,
  output logic          run_last_o
);

  logic [2:0] idx_q, idx_d;
  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic       begin_q, begin_d, end_q, end_d, last_q, last_d;
  logic       load;

  assign load  = status_i.not_empty && (!valid_q || !out_stall_i);
  assign pop_o = load && (idx_q == IDX_BRIGHT);

  always_comb begin
    byte_d  = SEG_BLANK;
    begin_d = 1'b0;
    end_d   = 1'b0;
    last_d  = 1'b0;
    case (idx_q)
      IDX_DATA: begin
        byte_d  = CMD_DATA;
        begin_d = 1'b1;
        end_d   = 1'b1;
      end
      IDX_ADDR: begin
        byte_d  = CMD_ADDR;
        begin_d = 1'b1;
      end
      IDX_DIG0: byte_d = status_i.head[0];
      IDX_DIG1: byte_d = status_i.head[1];
      IDX_DIG2: byte_d = status_i.head[2];
      IDX_DIG3: begin
        byte_d = status_i.head[3];
        end_d  = 1'b1;
      end
      IDX_BRIGHT: begin
        byte_d  = CMD_BRIGHT;
        begin_d = 1'b1;
        end_d   = 1'b1;
        last_d  = 1'b1;
      end
      default: byte_d = SEG_BLANK;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = (idx_q == IDX_BRIGHT) ? IDX_DATA : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= IDX_DATA;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= byte_d;
      begin_q <= begin_d;
      end_q   <= end_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign frame_byte_o  = byte_q;
  assign frame_begin_o = begin_q;
  assign frame_end_o   = end_q;
  assign run_last_o    = last_q;

endmodule
